// ===== design/bba_pkg.sv =====
// Shared constants, types and index helpers for the buddy block allocator.
package bba_pkg;

    localparam int REGION_BYTES    = 4096;
    localparam int MIN_BLOCK_BYTES = 32;
    localparam int TOP_ORDER       = $clog2(REGION_BYTES / MIN_BLOCK_BYTES);
    localparam int MIN_SHIFT       = $clog2(MIN_BLOCK_BYTES);
    localparam int NODE_COUNT      = 2 * (REGION_BYTES / MIN_BLOCK_BYTES) - 1;
    localparam int IDX_W           = $clog2(NODE_COUNT);
    localparam int DEPTH_W         = $clog2(TOP_ORDER + 1);
    localparam int OFF_W           = $clog2(REGION_BYTES);

    typedef logic [IDX_W-1:0]   t_idx;
    typedef logic [DEPTH_W-1:0] t_depth;
    typedef logic [OFF_W-1:0]   t_off;

    typedef enum logic [1:0] {
        NODE_ABSENT = 2'd0,
        NODE_FREE   = 2'd1,
        NODE_USED   = 2'd2,
        NODE_SPLIT  = 2'd3
    } t_node;

    typedef enum logic [1:0] {
        ST_ALLOC   = 2'd0,
        ST_OOM     = 2'd1,
        ST_FREED   = 2'd2,
        ST_IGNORED = 2'd3
    } t_status;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    // Write and read requests toward the node-state store.
    typedef struct packed {
        logic  en;
        t_idx  addr;
        t_node data;
    } t_wr_req;

    typedef struct packed {
        logic en;
        t_idx addr;
    } t_rd_req;

    // Heap index of the first node at a given depth.
    function automatic t_idx level_base(input t_depth d);
        logic [IDX_W:0] v;
        begin
            v = ({{IDX_W{1'b0}}, 1'b1} << d) - {{IDX_W{1'b0}}, 1'b1};
            level_base = v[IDX_W-1:0];
        end
    endfunction

    // Heap index of the last node at a given depth.
    function automatic t_idx level_last(input t_depth d);
        logic [IDX_W:0] v;
        begin
            v = ({{(IDX_W-1){1'b0}}, 2'd2} << d) - {{(IDX_W-1){1'b0}}, 2'd2};
            level_last = v[IDX_W-1:0];
        end
    endfunction

endpackage

// ===== design/bba_node_mem.sv =====
// Node-state store: one write and one registered read per cycle, with valid bits.
module bba_node_mem
    import bba_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_wr_req i_wr,
    input  t_rd_req i_rd,
    output t_node   o_rdata
);

    t_node                 r_mem [NODE_COUNT];
    logic [NODE_COUNT-1:0] r_vld;
    t_node                 r_rd_data;
    logic                  r_rd_vld;
    logic                  r_rd_root;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd.en) begin
            r_rd_data <= r_mem[i_rd.addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_rd_vld  <= 1'b0;
            r_rd_root <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_vld[i_wr.addr] <= 1'b1;
            end
            if (i_rd.en) begin
                r_rd_vld  <= r_vld[i_rd.addr];
                r_rd_root <= (i_rd.addr == '0);
            end
        end
    end

    // An entry never written holds its reset value: the root is free, others absent.
    assign o_rdata = r_rd_vld ? r_rd_data : (r_rd_root ? NODE_FREE : NODE_ABSENT);

endmodule

// ===== design/buddy_block_allocator.sv =====
// Buddy block allocator top level: request handling, tree walk and result register.
//
// The allocator manages a 4096-byte region in power-of-two blocks of 32 bytes
// and up, kept as a 255-node binary split tree in a single-port-read memory.
// An item with action 0 allocates: the byte count is rounded up to a block
// order, the lowest-address free block of that order (or of the next larger
// order that has one) is taken, split down as needed, and its offset is
// returned with status allocated; a request above 4096 bytes or with no free
// block returns out of memory with offset 0. An item with action 1 frees the
// leaf that starts at the given offset and merges free buddies upward; an
// offset outside the region or not at a leaf start returns free ignored.
// Exactly one result item follows every input item. Items are processed one
// at a time, and o_ready is high only while the block is idle. An allocate
// reads and checks each node it scans (at most 255 nodes, from the wanted
// level toward the root), writes a split node and a free right half per
// split level, then marks the block used; a free reads and checks one node
// per tree level it visits (at most eight), marks the leaf free, and per
// merge reads and checks the buddy, clears both halves and frees the parent,
// ending at the root or at a buddy that is not free. The tree comes out of
// reset ready for use, with no clearing pass. A finished result waits in an
// output register, and the next item is accepted while it waits.
module buddy_block_allocator
    import bba_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_action,
    input  logic [15:0] i_request_size,
    input  logic [15:0] i_block_offset,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic [11:0] o_granted_offset
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_A_RD,
        S_A_CHK,
        S_A_SPL,
        S_A_SPR,
        S_A_USE,
        S_F_RD,
        S_F_CHK,
        S_F_SET,
        S_M_RD,
        S_M_CHK,
        S_M_W1,
        S_M_W2,
        S_M_W3,
        S_DONE
    } t_state;

    t_state  r_state;
    t_idx    r_idx;
    t_depth  r_d;
    t_depth  r_td;
    t_off    r_off;
    t_off    r_start;
    t_status r_res_status;
    t_off    r_res_off;
    logic    r_out_vld;
    t_status r_out_status;
    t_off    r_out_off;

    t_wr_req w_wr;
    t_rd_req w_rd;
    t_node   w_node;

    // Order of the requested size: the smallest order whose block holds it.
    t_depth  w_order;
    logic    w_too_big;

    always_comb begin
        w_order = t_depth'(TOP_ORDER);
        for (int k = TOP_ORDER; k >= 0; k--) begin
            if (i_request_size <= 16'(MIN_BLOCK_BYTES << k)) begin
                w_order = t_depth'(k);
            end
        end
    end

    assign w_too_big = (i_request_size > 16'(REGION_BYTES));

    // Helpers for the current node.
    t_idx w_left;
    t_idx w_right;
    t_idx w_buddy;
    t_idx w_parent;
    t_idx w_j;
    t_off w_grant;
    t_off w_half;
    logic [OFF_W:0] w_mid;
    logic [3:0] w_shift;

    assign w_left   = t_idx'({r_idx, 1'b1});
    assign w_right  = t_idx'({r_idx, 1'b0} + 2);
    assign w_buddy  = r_idx[0] ? t_idx'(r_idx + 1'b1) : t_idx'(r_idx - 1'b1);
    assign w_parent = t_idx'((r_idx - 1'b1) >> 1);
    assign w_j      = r_idx - level_base(r_d);
    assign w_shift  = 4'(MIN_SHIFT + TOP_ORDER) - 4'(r_d);
    assign w_grant  = t_off'(w_j) << w_shift;
    assign w_half   = t_off'(REGION_BYTES / 2) >> r_d;
    assign w_mid    = {1'b0, r_start} + {1'b0, w_half};

    // Memory accesses follow directly from the state.
    always_comb begin
        w_wr = '0;
        w_rd = '0;
        unique case (r_state)
            S_A_RD, S_F_RD: begin
                w_rd.en   = 1'b1;
                w_rd.addr = r_idx;
            end
            S_M_RD: begin
                w_rd.en   = 1'b1;
                w_rd.addr = w_buddy;
            end
            S_A_SPL: begin
                w_wr = '{en: 1'b1, addr: r_idx, data: NODE_SPLIT};
            end
            S_A_SPR: begin
                w_wr = '{en: 1'b1, addr: w_right, data: NODE_FREE};
            end
            S_A_USE: begin
                w_wr = '{en: 1'b1, addr: r_idx, data: NODE_USED};
            end
            S_F_SET, S_M_W3: begin
                w_wr = '{en: 1'b1, addr: (r_state == S_M_W3) ? w_parent : r_idx,
                         data: NODE_FREE};
            end
            S_M_W1: begin
                w_wr = '{en: 1'b1, addr: r_idx, data: NODE_ABSENT};
            end
            S_M_W2: begin
                w_wr = '{en: 1'b1, addr: w_buddy, data: NODE_ABSENT};
            end
            default: begin
            end
        endcase
    end

    bba_node_mem u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_wr),
        .i_rd    (w_rd),
        .o_rdata (w_node)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            // In the done state the output register is reloaded instead.
            if (r_out_vld && i_ready && r_state != S_DONE) begin
                r_out_vld <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_res_off <= '0;
                        if (i_action == ACT_ALLOC) begin
                            if (w_too_big) begin
                                r_res_status <= ST_OOM;
                                r_state      <= S_DONE;
                            end else begin
                                // Scan starts at the leftmost node of the wanted level.
                                r_td    <= t_depth'(TOP_ORDER) - w_order;
                                r_d     <= t_depth'(TOP_ORDER) - w_order;
                                r_idx   <= level_base(t_depth'(TOP_ORDER) - w_order);
                                r_state <= S_A_RD;
                            end
                        end else begin
                            if (i_block_offset >= 16'(REGION_BYTES)) begin
                                r_res_status <= ST_IGNORED;
                                r_state      <= S_DONE;
                            end else begin
                                r_off   <= i_block_offset[OFF_W-1:0];
                                r_start <= '0;
                                r_idx   <= '0;
                                r_d     <= '0;
                                r_state <= S_F_RD;
                            end
                        end
                    end
                end
                S_A_RD: begin
                    r_state <= S_A_CHK;
                end
                S_A_CHK: begin
                    if (w_node == NODE_FREE) begin
                        r_state <= (r_d == r_td) ? S_A_USE : S_A_SPL;
                    end else if (r_idx == level_last(r_d)) begin
                        if (r_d == '0) begin
                            r_res_status <= ST_OOM;
                            r_state      <= S_DONE;
                        end else begin
                            r_d     <= r_d - 1'b1;
                            r_idx   <= level_base(r_d - 1'b1);
                            r_state <= S_A_RD;
                        end
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_A_RD;
                    end
                end
                S_A_SPL: begin
                    r_state <= S_A_SPR;
                end
                S_A_SPR: begin
                    // The right half is now free; continue in the left half.
                    r_idx   <= w_left;
                    r_d     <= r_d + 1'b1;
                    r_state <= ((r_d + 1'b1) == r_td) ? S_A_USE : S_A_SPL;
                end
                S_A_USE: begin
                    r_res_status <= ST_ALLOC;
                    r_res_off    <= w_grant;
                    r_state      <= S_DONE;
                end
                S_F_RD: begin
                    r_state <= S_F_CHK;
                end
                S_F_CHK: begin
                    if (w_node == NODE_FREE || w_node == NODE_USED) begin
                        if (r_start == r_off) begin
                            r_state <= S_F_SET;
                        end else begin
                            r_res_status <= ST_IGNORED;
                            r_state      <= S_DONE;
                        end
                    end else if (w_node == NODE_SPLIT && r_d != t_depth'(TOP_ORDER)) begin
                        if ({1'b0, r_off} >= w_mid) begin
                            r_start <= w_mid[OFF_W-1:0];
                            r_idx   <= w_right;
                        end else begin
                            r_idx   <= w_left;
                        end
                        r_d     <= r_d + 1'b1;
                        r_state <= S_F_RD;
                    end else begin
                        r_res_status <= ST_IGNORED;
                        r_state      <= S_DONE;
                    end
                end
                S_F_SET: begin
                    r_res_status <= ST_FREED;
                    r_state      <= (r_idx == '0) ? S_DONE : S_M_RD;
                end
                S_M_RD: begin
                    r_state <= S_M_CHK;
                end
                S_M_CHK: begin
                    r_state <= (w_node == NODE_FREE) ? S_M_W1 : S_DONE;
                end
                S_M_W1: begin
                    r_state <= S_M_W2;
                end
                S_M_W2: begin
                    r_state <= S_M_W3;
                end
                S_M_W3: begin
                    r_idx   <= w_parent;
                    r_state <= (w_parent == '0) ? S_DONE : S_M_RD;
                end
                S_DONE: begin
                    if (!r_out_vld || i_ready) begin
                        r_out_vld    <= 1'b1;
                        r_out_status <= r_res_status;
                        r_out_off    <= r_res_off;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_ready          = (r_state == S_IDLE);
    assign o_valid          = r_out_vld;
    assign o_status         = r_out_status;
    assign o_granted_offset = r_out_off;

endmodule

// ===== design/bba_checker.sv =====
// Port-level checks for the buddy block allocator, bound to the top level.
module bba_checker
    import bba_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [1:0]  o_status,
    input logic [11:0] o_granted_offset
);

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status) && $stable(o_granted_offset))
        else $error("result changed while stalled");

    // Only an allocation carries a nonzero offset.
    a_zero_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_ALLOC |-> o_granted_offset == '0)
        else $error("nonzero offset without allocation");

    // Granted blocks are aligned to the smallest block size.
    a_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_ALLOC |-> o_granted_offset[MIN_SHIFT-1:0] == '0)
        else $error("misaligned grant");

    // One item at a time: an accepted item closes the input side.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("second item accepted while busy");

    // No result appears right out of reset.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind buddy_block_allocator bba_checker u_bba_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_valid          (i_valid),
    .o_ready          (o_ready),
    .o_valid          (o_valid),
    .i_ready          (i_ready),
    .o_status         (o_status),
    .o_granted_offset (o_granted_offset)
);

// ===== sim/buddy_block_allocator_test.sv =====
// Self-checking testbench for the buddy block allocator.
`timescale 1ns / 1ps

module buddy_block_allocator_test;
    import bba_pkg::*;

    typedef struct {
        logic        action;
        logic [15:0] size;
        logic [15:0] offset;
    } t_request;

    typedef struct {
        t_status     status;
        logic [11:0] granted;
    } t_outcome;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic        i_action = ACT_ALLOC;
    logic [15:0] i_request_size = '0;
    logic [15:0] i_block_offset = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [1:0]  o_status;
    logic [11:0] o_granted_offset;

    buddy_block_allocator u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_action         (i_action),
        .i_request_size   (i_request_size),
        .i_block_offset   (i_block_offset),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_status         (o_status),
        .o_granted_offset (o_granted_offset)
    );

    always #2 i_clk = ~i_clk;

    // The predictor keeps its own copy of the split tree in heap order.
    t_node    tree_model [NODE_COUNT];
    t_request pending_requests [$];
    t_outcome expected_outcomes [$];
    int       error_count = 0;
    bit       stimulus_done = 1'b0;
    // When set, both sides stop idling for a stretch.
    bit       busy_stretch = 1'b0;
    // Offsets of blocks the model currently holds as used, for targeted frees.
    int       held_offsets [$];

    // Merge free buddy pairs upward from a freed leaf.
    function automatic void merge_buddies(input int idx);
        int par;
        while (idx > 0) begin
            par = (idx - 1) / 2;
            if (tree_model[2*par+1] != NODE_FREE || tree_model[2*par+2] != NODE_FREE)
                return;
            tree_model[2*par+1] = NODE_ABSENT;
            tree_model[2*par+2] = NODE_ABSENT;
            tree_model[par]     = NODE_FREE;
            idx = par;
        end
    endfunction

    function automatic t_outcome predict_allocation(input t_request req);
        t_outcome res;
        int order, bytes, d, idx, want_depth;
        res.status  = ST_OOM;
        res.granted = '0;
        order = 0;
        bytes = MIN_BLOCK_BYTES;
        while (bytes < req.size && order <= TOP_ORDER) begin
            bytes = bytes * 2;
            order++;
        end
        if (order > TOP_ORDER) return res;
        want_depth = TOP_ORDER - order;
        for (int k = order; k <= TOP_ORDER; k++) begin
            d = TOP_ORDER - k;
            for (int j = 0; j < (1 << d); j++) begin
                idx = (1 << d) - 1 + j;
                if (tree_model[idx] != NODE_FREE) continue;
                // Split down to the wanted order, keeping the lower half.
                while (d < want_depth) begin
                    tree_model[idx]       = NODE_SPLIT;
                    tree_model[2*idx+1]   = NODE_FREE;
                    tree_model[2*idx+2]   = NODE_FREE;
                    idx = 2 * idx + 1;
                    d++;
                end
                tree_model[idx] = NODE_USED;
                res.status  = ST_ALLOC;
                res.granted = 12'((idx - ((1 << d) - 1)) * (REGION_BYTES >> d));
                return res;
            end
        end
        return res;
    endfunction

    function automatic t_outcome predict_release(input t_request req);
        t_outcome res;
        int idx, start, span;
        res.status  = ST_IGNORED;
        res.granted = '0;
        if (req.offset >= REGION_BYTES) return res;
        idx = 0;
        start = 0;
        span = REGION_BYTES;
        while (idx < NODE_COUNT) begin
            if (tree_model[idx] == NODE_FREE || tree_model[idx] == NODE_USED) begin
                if (start != req.offset) return res;
                tree_model[idx] = NODE_FREE;
                merge_buddies(idx);
                res.status = ST_FREED;
                return res;
            end
            if (tree_model[idx] != NODE_SPLIT) return res;
            span = span / 2;
            if (req.offset >= start + span) begin
                start += span;
                idx = 2 * idx + 2;
            end else begin
                idx = 2 * idx + 1;
            end
        end
        return res;
    endfunction

    // Queue an item and track held blocks so that later frees can hit them.
    task automatic queue_request(input logic act, input int size, input int offset);
        t_request req;
        t_outcome res;
        req.action = act;
        req.size   = 16'(size);
        req.offset = 16'(offset);
        pending_requests.push_back(req);
        if (act == ACT_ALLOC) begin
            res = predict_allocation(req);
            if (res.status == ST_ALLOC) held_offsets.push_back(res.granted);
        end else begin
            res = predict_release(req);
            if (res.status == ST_FREED)
                foreach (held_offsets[i])
                    if (held_offsets[i] == req.offset) begin
                        held_offsets.delete(i);
                        break;
                    end
        end
        expected_outcomes.push_back(res);
    endtask

    // Driver: present the next queued item, holding it until accepted.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (!i_valid || o_ready) begin
                if (pending_requests.size() > 0 &&
                        (busy_stretch || $urandom_range(99) >= 26)) begin
                    t_request req;
                    req = pending_requests.pop_front();
                    i_valid        <= 1'b1;
                    i_action       <= req.action;
                    i_request_size <= req.size;
                    i_block_offset <= req.offset;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: randomized ready and a check of each accepted result.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (expected_outcomes.size() == 0) begin
                    $error("unexpected result: status %0d offset %0d",
                           o_status, o_granted_offset);
                    error_count++;
                end else begin
                    t_outcome exp_res;
                    exp_res = expected_outcomes.pop_front();
                    if (o_status !== exp_res.status) begin
                        $error("status: expected %0d actual %0d", exp_res.status, o_status);
                        error_count++;
                    end
                    if (o_granted_offset !== exp_res.granted) begin
                        $error("granted_offset: expected %0d actual %0d",
                               exp_res.granted, o_granted_offset);
                        error_count++;
                    end
                end
            end
            i_ready <= busy_stretch || ($urandom_range(99) >= 26);
        end
    end

    // Generous time limit for the whole run.
    initial begin
        #(64'd4 * 64'd3_000_000);
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        int kind, pick;
        foreach (tree_model[i]) tree_model[i] = NODE_ABSENT;
        tree_model[0] = NODE_FREE;

        // Directed part: size extremes, zero size, oversize, odd frees.
        queue_request(ACT_ALLOC, 0, 0);
        queue_request(ACT_ALLOC, 1, 0);
        queue_request(ACT_ALLOC, 33, 0);
        queue_request(ACT_ALLOC, 4097, 0);
        queue_request(ACT_ALLOC, 16'hFFFF, 0);
        queue_request(ACT_FREE, 0, 16'hFFFF);
        queue_request(ACT_FREE, 0, 4096);
        queue_request(ACT_FREE, 0, 40);
        queue_request(ACT_FREE, 0, 32);
        queue_request(ACT_FREE, 0, 32);
        queue_request(ACT_FREE, 0, 0);
        queue_request(ACT_FREE, 0, 64);
        queue_request(ACT_ALLOC, 4096, 0);
        queue_request(ACT_ALLOC, 32, 0);
        queue_request(ACT_FREE, 16'hFFFF, 0);
        queue_request(ACT_ALLOC, 2048, 0);
        queue_request(ACT_ALLOC, 2048, 0);
        queue_request(ACT_ALLOC, 2049, 0);
        queue_request(ACT_FREE, 0, 2048);
        queue_request(ACT_FREE, 0, 0);

        // Random part: mostly allocates and frees of held blocks.
        for (int n = 0; n < 1350; n++) begin
            kind = $urandom_range(99);
            if (kind < 45) begin
                if ($urandom_range(9) == 0) queue_request(ACT_ALLOC, $urandom, $urandom);
                else queue_request(ACT_ALLOC, $urandom_range(1 << $urandom_range(12)),
                                   $urandom);
            end else if (kind < 85 && held_offsets.size() > 0) begin
                pick = $urandom_range(held_offsets.size() - 1);
                queue_request(ACT_FREE, $urandom, held_offsets[pick]);
            end else if (kind < 93) begin
                queue_request(ACT_FREE, $urandom, $urandom_range(127) * 32);
            end else begin
                queue_request(ACT_FREE, $urandom, $urandom);
            end
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_requests.size() > 0 || expected_outcomes.size() > 0) begin
            @(posedge i_clk);
            // A stretch with no idling in the middle of the run.
            busy_stretch <= (pending_requests.size() > 500 && pending_requests.size() < 700);
        end
        repeat (600) @(posedge i_clk);
        if (error_count == 0 && expected_outcomes.size() == 0 && !o_valid)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
